// ===== rtl/ttb_pkg.sv =====
// Shared types and constants for the triangle tangent/bitangent block.
`default_nettype none
package ttb_pkg;
  localparam int unsigned FracBitsDefault = 16;
  localparam logic [31:0] AreaThreshReset = 32'd42950;

  // Corner record handed from the front end to the back end
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic               third;
  } corner_t;
endpackage
`default_nettype wire

// ===== rtl/ttb_front.sv =====
// Front end: accepts corners, tags the closing corner of each triangle, queues them.
`default_nettype none
module ttb_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [159:0]    in_data_i,
  output logic                 q_valid_o,
  input  wire logic            q_ready_i,
  output ttb_pkg::corner_t     q_data_o
);
  localparam int unsigned Depth = 2;

  ttb_pkg::corner_t fifo_q [Depth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic [1:0] cc_q;
  logic       push, pop;
  ttb_pkg::corner_t wr;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = fifo_q[rp_q];

  always_comb begin
    wr.pos_x = in_data_i[31:0];
    wr.pos_y = in_data_i[63:32];
    wr.pos_z = in_data_i[95:64];
    wr.tex_u = in_data_i[127:96];
    wr.tex_v = in_data_i[159:128];
    wr.third = (cc_q == 2'd2);
  end

  // Write queue entries
  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= wr;
  end

  // Advance pointers, count and corner tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0; cc_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
        cc_q <= (cc_q == 2'd2) ? 2'd0 : cc_q + 2'd1;
      end
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  ap_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  ap_cc: assert property (@(posedge clk_i) disable iff (!rst_ni) cc_q != 2'd3)
    else $error("corner tag out of range");
  ap_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
    else $error("full queue drained without pop");
endmodule
`default_nettype wire

// ===== rtl/ttb_back.sv =====
// Back end: holds corners, forms area and numerators, divides, saturates.
`default_nettype none
module ttb_back #(
  parameter int unsigned FRACTION_BITS = ttb_pkg::FracBitsDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [31:0]   thresh_i,
  input  wire logic          q_valid_i,
  output logic               q_ready_o,
  input  ttb_pkg::corner_t   q_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [193:0]       out_data_o
);
  localparam int unsigned DW = 68 + FRACTION_BITS;   // shifted numerator width
  localparam int unsigned CW = $clog2(DW + 1);

  localparam logic [2:0] S_IDLE = 3'd0, S_AREA = 3'd1, S_NUM = 3'd2,
                         S_DIV  = 3'd3, S_OUT  = 3'd4;

  logic [2:0] st_q;
  logic signed [31:0] p0_q [3];
  logic signed [31:0] p1_q [3];
  logic signed [31:0] u0_q, v0_q, u1_q, v1_q;
  logic signed [32:0] dp1_q [3];
  logic signed [32:0] dp2_q [3];
  logic signed [32:0] du1_q, dv1_q, du2_q, dv2_q;
  logic [66:0]        absa_q;
  logic               aneg_q;
  logic [2:0]         comp_q;          // which of six quotients
  logic [1:0]         ph_q;            // numerator phase
  logic signed [67:0] pa_q, pb_q;
  logic [DW-1:0]      m_q;
  logic [67:0]        r_q;
  logic [CW-1:0]      bit_q;
  logic               nneg_q, sat_q, held_q;
  logic [31:0]        res_q [6];
  logic               deg_q;
  logic [193:0]       obuf_q;
  logic               ovalid_q;

  // Multiplier operand select for numerators
  logic signed [32:0] ma, mb, mc, md;
  logic [1:0] ci;
  always_comb begin
    ci = (comp_q >= 3'd3) ? 2'(comp_q - 3'd3) : comp_q[1:0];
    if (comp_q < 3'd3) begin
      ma = dp1_q[ci]; mb = dv2_q; mc = dp2_q[ci]; md = dv1_q;
    end else begin
      ma = dp2_q[ci]; mb = du1_q; mc = dp1_q[ci]; md = du2_q;
    end
  end

  logic signed [67:0] num, num_adj;
  logic [67:0] nmag;
  assign num     = pa_q - pb_q;
  assign num_adj = aneg_q ? -num : num;
  assign nmag    = num_adj[67] ? 68'(-num_adj) : num_adj;

  // Restoring division step
  logic [68:0] rsh, rsub;
  assign rsh  = {r_q, m_q[DW-1]};
  assign rsub = rsh - {2'b00, absa_q};

  logic [DW-1:0] qmag;
  logic [DW-1:0] qsh;
  assign qsh = m_q;  // after DW steps m_q holds the quotient bits
  assign qmag = qsh;

  logic qsat;
  logic [31:0] qres;
  always_comb begin
    if (nneg_q) begin
      qsat = (qmag > DW'(33'h080000000));
      qres = qsat ? 32'h80000000 : 32'(-qmag[31:0]);
    end else begin
      qsat = (qmag > DW'(32'h7FFFFFFF));
      qres = qsat ? 32'h7FFFFFFF : qmag[31:0];
    end
  end

  assign q_ready_o = (st_q == S_IDLE);

  // Hold corners and compute deltas
  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o) begin
      if (!q_data_i.third) begin
        if (!held_q) begin
          p0_q[0] <= q_data_i.pos_x; p0_q[1] <= q_data_i.pos_y;
          p0_q[2] <= q_data_i.pos_z; u0_q <= q_data_i.tex_u; v0_q <= q_data_i.tex_v;
        end else begin
          p1_q[0] <= q_data_i.pos_x; p1_q[1] <= q_data_i.pos_y;
          p1_q[2] <= q_data_i.pos_z; u1_q <= q_data_i.tex_u; v1_q <= q_data_i.tex_v;
        end
      end else begin
        dp1_q[0] <= 33'(p1_q[0]) - 33'(p0_q[0]);
        dp1_q[1] <= 33'(p1_q[1]) - 33'(p0_q[1]);
        dp1_q[2] <= 33'(p1_q[2]) - 33'(p0_q[2]);
        dp2_q[0] <= 33'(q_data_i.pos_x) - 33'(p0_q[0]);
        dp2_q[1] <= 33'(q_data_i.pos_y) - 33'(p0_q[1]);
        dp2_q[2] <= 33'(q_data_i.pos_z) - 33'(p0_q[2]);
        du1_q <= 33'(u1_q) - 33'(u0_q);
        dv1_q <= 33'(v1_q) - 33'(v0_q);
        du2_q <= 33'(q_data_i.tex_u) - 33'(u0_q);
        dv2_q <= 33'(q_data_i.tex_v) - 33'(v0_q);
      end
    end
  end

  // Sequencer: area, then, unless degenerate, per component two products and a bit-serial divide
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; held_q <= 1'b0; ovalid_q <= 1'b0; comp_q <= '0;
      ph_q <= '0; bit_q <= '0; sat_q <= 1'b0; deg_q <= 1'b0;
    end else begin
      // Drop the beat once taken, unless a new one replaces it this cycle
      if (ovalid_q && out_ready_i && st_q != S_OUT) ovalid_q <= 1'b0;
      unique case (st_q)
        S_IDLE: if (q_valid_i) begin
          if (q_data_i.third) begin
            st_q <= S_AREA; held_q <= 1'b0; ph_q <= '0;
          end else held_q <= ~held_q;
        end
        S_AREA: begin
          if (ph_q == 2'd0) begin
            pa_q <= 68'(du1_q * dv2_q); ph_q <= 2'd1;
          end else if (ph_q == 2'd1) begin
            pb_q <= 68'(dv1_q * du2_q); ph_q <= 2'd2;
          end else begin
            aneg_q <= num[67];
            absa_q <= num[67] ? 67'(-num) : num[66:0];
            deg_q <= 1'b0; sat_q <= 1'b0; comp_q <= '0; ph_q <= '0;
            st_q <= S_NUM;
          end
        end
        S_NUM: begin
          if ({1'b0, absa_q} <= {36'd0, thresh_i}) begin
            deg_q <= 1'b1; st_q <= S_OUT;
          end else if (ph_q == 2'd0) begin
            pa_q <= 68'(ma * mb); ph_q <= 2'd1;
          end else if (ph_q == 2'd1) begin
            pb_q <= 68'(mc * md); ph_q <= 2'd2;
          end else begin
            nneg_q <= num_adj[67];
            m_q <= DW'(nmag) << FRACTION_BITS;
            r_q <= '0; bit_q <= CW'(DW); st_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (bit_q != '0) begin
            if (!rsub[68]) begin
              r_q <= rsub[67:0]; m_q <= {m_q[DW-2:0], 1'b1};
            end else begin
              r_q <= rsh[67:0]; m_q <= {m_q[DW-2:0], 1'b0};
            end
            bit_q <= bit_q - CW'(1);
          end else begin
            res_q[comp_q] <= qres;
            sat_q <= sat_q | qsat;
            ph_q <= '0;
            if (comp_q == 3'd5) st_q <= S_OUT;
            else begin comp_q <= comp_q + 3'd1; st_q <= S_NUM; end
          end
        end
        S_OUT: if (!ovalid_q || out_ready_i) begin
          ovalid_q <= 1'b1;
          if (deg_q) obuf_q <= {1'b0, 1'b1, 192'd0};
          else obuf_q <= {sat_q, 1'b0, res_q[5], res_q[4], res_q[3],
                          res_q[2], res_q[1], res_q[0]};
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = obuf_q;

  ap_deg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o[192]) |-> out_data_o[191:0] == '0 && !out_data_o[193])
    else $error("degenerate result carries data");
  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> !q_ready_o)
    else $error("ready while busy");
  ap_comp: assert property (@(posedge clk_i) disable iff (!rst_ni) comp_q <= 3'd5)
    else $error("component index out of range");
endmodule
`default_nettype wire

// ===== rtl/triangle_tangent_bitangent.sv =====
// Top level of the triangle tangent/bitangent block.
// Usage: corners stream in on s_axis, one per beat; tdata packs pos_x, pos_y,
// pos_z, tex_u, tex_v (32 bits each, signed Q16.16, pos_x lowest).
// Every third corner closes a triangle and yields one beat on m_axis with the
// tangent and bitangent (Q16.16, saturated), a degenerate flag and a
// saturation flag. The first two corners of a triangle yield nothing.
// A closing corner gives its result after forming the area and, for each of six
// components, two multiplies plus a one-bit-per-cycle restoring divide; a
// degenerate triangle skips the component work. Throughput: one triangle per
// divide sequence; the front queue takes corners while the back end works until
// its two entries fill, and the back end takes corners only while idle.
// The user must write area_threshold (cfg_we_i/cfg_wdata_i) only while idle;
// the block does not enforce this. Reset clears the corner count, the queue and
// the output beat and loads the threshold default; held corners need no reset.
// If m_axis_tready stays low, the result beat is held and the back end stalls,
// then the queue fills and s_axis_tready drops.
`default_nettype none
module triangle_tangent_bitangent #(
  parameter int unsigned FRACTION_BITS = ttb_pkg::FracBitsDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [31:0]   cfg_wdata_i,     // area_threshold
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [159:0]  s_axis_tdata,    // pos_x, pos_y, pos_z, tex_u, tex_v
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z,
  // degenerate, saturated
  output logic [199:0]       m_axis_tdata
);
  logic [31:0] thresh_q;
  logic q_valid, q_ready;
  ttb_pkg::corner_t q_data;
  logic [193:0] res;

  // Hold the threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thresh_q <= ttb_pkg::AreaThreshReset;
    else if (cfg_we_i) thresh_q <= cfg_wdata_i;
  end

  ttb_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_data_i(s_axis_tdata),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  ttb_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk_i, .rst_ni, .thresh_i(thresh_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(res)
  );

  assign m_axis_tdata = {6'd0, res};
endmodule
`default_nettype wire

// ===== dv/tb_triangle_tangent_bitangent.sv =====
// Testbench for triangle_tangent_bitangent: directed and random corners, scoreboard check.
`timescale 1ns / 100ps
`default_nettype none
module tb_triangle_tangent_bitangent;
  localparam int unsigned FracBits = ttb_pkg::FracBitsDefault;
  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned SettleCycles = 6 * (FracBits + 72) + 64;

  // Result beat layout, highest bits first
  typedef struct packed {
    logic [5:0]  pad;
    logic        saturated;
    logic        degenerate;
    logic [31:0] bitangent_z;
    logic [31:0] bitangent_y;
    logic [31:0] bitangent_x;
    logic [31:0] tangent_z;
    logic [31:0] tangent_y;
    logic [31:0] tangent_x;
  } frame_t;

  typedef struct {
    logic [31:0] px, py, pz, u, v;
  } corner_in_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [31:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [199:0] m_axis_tdata;

  triangle_tangent_bitangent dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // Model state
  logic [31:0]         area_thresh = ttb_pkg::AreaThreshReset;
  logic signed [127:0] held_pos[6];
  logic signed [127:0] held_uv[4];
  int unsigned         corners_held = 0;
  frame_t              expected_frames[$];
  int unsigned         err_count = 0;
  int unsigned         cycle_cnt = 0;
  int unsigned         tx_idle_pct = 0;
  int unsigned         rx_idle_pct = 0;
  int unsigned         rx_hold_cycles = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: long hold-off when requested, otherwise random stalls
  always @(posedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // One quotient: num * 2^F / den, truncated toward zero, saturated
  function automatic logic [31:0] sat_quotient(input logic signed [127:0] num,
                                               input logic [127:0] den,
                                               inout logic sat);
    logic        neg;
    logic [127:0] mag;
    logic [127:0] q;
    logic [127:0] limit;
    neg   = num < 0;
    mag   = neg ? -num : num;
    q     = (mag << FracBits) / den;
    limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > limit) begin
      q   = limit;
      sat = 1'b1;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  // Advance the corner model by one accepted corner
  function automatic void track_corner(input corner_in_t c);
    logic signed [127:0] p[3];
    logic signed [127:0] dp1, dp2, du1, dv1, du2, dv2, area, tn, bn;
    logic [127:0]        abs_area;
    logic                sat;
    frame_t              f;
    p[0] = 128'(signed'(c.px));
    p[1] = 128'(signed'(c.py));
    p[2] = 128'(signed'(c.pz));
    if (corners_held < 2) begin
      for (int k = 0; k < 3; k++) held_pos[corners_held * 3 + k] = p[k];
      held_uv[corners_held * 2]     = 128'(signed'(c.u));
      held_uv[corners_held * 2 + 1] = 128'(signed'(c.v));
      corners_held++;
      return;
    end
    corners_held = 0;
    du1 = held_uv[2] - held_uv[0];
    dv1 = held_uv[3] - held_uv[1];
    du2 = 128'(signed'(c.u)) - held_uv[0];
    dv2 = 128'(signed'(c.v)) - held_uv[1];
    area = du1 * dv2 - dv1 * du2;
    abs_area = (area < 0) ? -area : area;
    f = '0;
    sat = 1'b0;
    if (abs_area <= {96'd0, area_thresh}) begin
      f.degenerate = 1'b1;
    end else begin
      for (int k = 0; k < 3; k++) begin
        dp1 = held_pos[3 + k] - held_pos[k];
        dp2 = p[k] - held_pos[k];
        tn = dp1 * dv2 - dp2 * dv1;
        bn = dp2 * du1 - dp1 * du2;
        if (area < 0) begin
          tn = -tn;
          bn = -bn;
        end
        case (k)
          0: begin
            f.tangent_x   = sat_quotient(tn, abs_area, sat);
            f.bitangent_x = sat_quotient(bn, abs_area, sat);
          end
          1: begin
            f.tangent_y   = sat_quotient(tn, abs_area, sat);
            f.bitangent_y = sat_quotient(bn, abs_area, sat);
          end
          default: begin
            f.tangent_z   = sat_quotient(tn, abs_area, sat);
            f.bitangent_z = sat_quotient(bn, abs_area, sat);
          end
        endcase
      end
      f.saturated = sat;
    end
    expected_frames.insert(expected_frames.size(), f);
  endfunction

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    frame_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = frame_t'(m_axis_tdata);
      if (expected_frames.size() == 0) begin
        $error("result beat with no expectation pending");
        err_count++;
      end else begin
        want = expected_frames.pop_front();
        if (got.tangent_x !== want.tangent_x) begin
          $error("tangent_x exp %h got %h", want.tangent_x, got.tangent_x); err_count++;
        end
        if (got.tangent_y !== want.tangent_y) begin
          $error("tangent_y exp %h got %h", want.tangent_y, got.tangent_y); err_count++;
        end
        if (got.tangent_z !== want.tangent_z) begin
          $error("tangent_z exp %h got %h", want.tangent_z, got.tangent_z); err_count++;
        end
        if (got.bitangent_x !== want.bitangent_x) begin
          $error("bitangent_x exp %h got %h", want.bitangent_x, got.bitangent_x); err_count++;
        end
        if (got.bitangent_y !== want.bitangent_y) begin
          $error("bitangent_y exp %h got %h", want.bitangent_y, got.bitangent_y); err_count++;
        end
        if (got.bitangent_z !== want.bitangent_z) begin
          $error("bitangent_z exp %h got %h", want.bitangent_z, got.bitangent_z); err_count++;
        end
        if (got.degenerate !== want.degenerate) begin
          $error("degenerate exp %b got %b", want.degenerate, got.degenerate); err_count++;
        end
        if (got.saturated !== want.saturated) begin
          $error("saturated exp %b got %b", want.saturated, got.saturated); err_count++;
        end
        if (got.pad !== '0) begin
          $error("pad exp %h got %h", 6'd0, got.pad); err_count++;
        end
      end
    end
  end

  // Offer one corner beat, with random idle beforehand, and track it once taken
  task automatic send_corner(input corner_in_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c.v, c.u, c.pz, c.py, c.px};
    do @(posedge clk_i); while (!s_axis_tready);
    track_corner(c);
  endtask

  task automatic send_tri(input corner_in_t a, input corner_in_t b, input corner_in_t c);
    send_corner(a);
    send_corner(b);
    send_corner(c);
  endtask

  // Wait until every expectation is met and the block has settled
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    area_thresh = value;
  endtask

  function automatic corner_in_t mk(input logic [31:0] px, py, pz, u, v);
    corner_in_t c;
    c.px = px; c.py = py; c.pz = pz; c.u = u; c.v = v;
    return c;
  endfunction

  // Small values stay within +-8.0; wide values cover all bits
  function automatic logic [31:0] rnd_coord(input bit wide);
    if (wide) return $urandom();
    return $urandom_range(32'h0010_0000) - 32'h0008_0000;
  endfunction

  task automatic test_directed();
    corner_in_t o;
    o = mk(0, 0, 0, 0, 0);
    // area exactly at default threshold: degenerate; one above: not
    send_tri(o, mk(1, 2, 3, 1, 0), mk(4, 5, 6, 0, 42950));
    send_tri(o, mk(1 << 16, 2, 3, 1, 0), mk(4, 5, 6, 0, 42951));
    // unit UV square: tangent equals dP1, exact negative minimum
    send_tri(o, mk(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0001_0000, 0),
             mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0, 32'h0001_0000));
    // clipped positive: dP1 = 2^32 - 1
    send_tri(mk(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0),
             mk(32'h7FFF_FFFF, 32'h8000_0000, 5, 32'h0001_0000, 0),
             mk(32'h8000_0000, 32'h7FFF_FFFF, 7, 0, 32'h0001_0000));
    // extreme UVs, negative area, identical UVs
    send_tri(mk(32'hFFFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF),
             mk(0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000),
             mk(32'h1234_5678, 32'h8765_4321, 0, 32'h8000_0000, 32'h8000_0000));
    send_tri(mk(1, 2, 3, 5, 5), mk(4, 5, 6, 5, 5), mk(7, 8, 9, 5, 5));
    send_tri(o, mk(3, 0, 0, 0, 1), mk(0, 3, 0, 1, 0));
    drain();
    // boundary at zero and full-scale threshold
    write_threshold('0);
    send_tri(o, mk(7, 7, 7, 1, 0), mk(1, 1, 1, 0, 1));
    send_tri(o, mk(7, 7, 7, 1, 0), mk(1, 1, 1, 2, 0));
    drain();
    write_threshold(32'hFFFF_FFFF);
    send_tri(o, mk(32'h0001_0000, 0, 0, 32'h0001_0000, 0),
             mk(0, 32'h0001_0000, 0, 0, 32'h0000_FFFF));
    send_tri(o, mk(32'h0001_0000, 0, 0, 32'h0001_0000, 0),
             mk(0, 32'h0001_0000, 0, 0, 32'h0001_0000));
    drain();
  endtask

  task automatic test_random(input int unsigned n_tri, input int unsigned tx_pct,
                             input int unsigned rx_pct, input bit hold_off);
    corner_in_t c[3];
    int unsigned mode;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int unsigned t = 0; t < n_tri; t++) begin
      if (hold_off && t == n_tri / 2) rx_hold_cycles = 20000;
      mode = $urandom_range(9);
      for (int k = 0; k < 3; k++) begin
        c[k] = mk(rnd_coord(mode < 2), rnd_coord(mode < 2), rnd_coord(mode < 2),
                  rnd_coord(mode < 3), rnd_coord(mode < 3));
      end
      // collapsed UV triangle
      if (mode == 9) begin
        c[2].u = c[0].u;
        c[2].v = c[0].v;
      end
      send_tri(c[0], c[1], c[2]);
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_threshold(ttb_pkg::AreaThreshReset);
    test_random(215, 21, 52, 1'b0);
    write_threshold($urandom());
    test_random(215, 52, 21, 1'b0);
    write_threshold('0);
    test_random(215, 0, 0, 1'b1);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
